/* design/lfsq_pkg.sv */
// Shared widths, register indexes and reset values for the largest free square finder.
// No dependencies; every other design file refers to this package by scoped names.
package lfsq_pkg;

	localparam int CHAR_W    = 8;
	localparam int SCORE_W   = 11;
	localparam int ROW_W     = 16;
	localparam int COLS_W    = 11;
	localparam int LCOL_W    = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam int DEFAULT_MAX_COLUMNS = 1024;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_CHAR = 2'd2;

	localparam logic [ROW_W-1:0]  GRID_ROWS_RST     = 16'd1;
	localparam logic [COLS_W-1:0] GRID_COLUMNS_RST  = 11'd1;
	localparam logic [CHAR_W-1:0] OBSTACLE_CHAR_RST = 8'd111;

	// per-cell context carried from the input register to the scoring logic
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic obstacle;
		logic last_cell;
	} cell_ctx_t;

endpackage

/* design/largest_free_square_finder_unit.sv */
// Largest free square finder: maximal-square scoring over a raster stream of grid cells.
// A grid's result is registered: its last cell passes the input register, then loads the result register.
// Throughput: one cell per cycle while no waiting result stalls, fed by the line store read and score loop.
// A waiting result stalls the next grid's last cell in the input register; new cells wait behind it.
// Reset: arst_n clears control, counters, scores and configuration registers to defaults at once;
// the line store is not cleared, as the scores read for the first row are taken as zero.
module largest_free_square_finder_unit #(
	parameter int MAX_COLUMNS = lfsq_pkg::DEFAULT_MAX_COLUMNS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lfsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfsq_pkg::CFG_DAT_W-1:0]  cfg_data,
	// cell input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lfsq_pkg::CHAR_W-1:0]     cell_char,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lfsq_pkg::SCORE_W-1:0]    square_size,
	output logic [lfsq_pkg::ROW_W-1:0]      top_row,
	output logic [lfsq_pkg::LCOL_W-1:0]     left_col
);

	localparam int COL_W = $clog2(MAX_COLUMNS);
	// width that holds both a column count plus one and the column register
	localparam int CMP_W = (COL_W + 1 > lfsq_pkg::COLS_W) ? COL_W + 1 : lfsq_pkg::COLS_W;

	// configuration registers
	logic [lfsq_pkg::ROW_W-1:0]   grid_rows_q;
	logic [lfsq_pkg::COLS_W-1:0]  grid_columns_q;
	logic [lfsq_pkg::CHAR_W-1:0]  obstacle_char_q;

	// raster position of the next cell to be accepted
	logic [lfsq_pkg::ROW_W-1:0]   row_count_q;
	logic [COL_W-1:0]             col_count_q;

	// input register stage
	logic                         valid_s1;
	lfsq_pkg::cell_ctx_t          ctx_s1;
	logic [lfsq_pkg::ROW_W-1:0]   row_s1;
	logic [COL_W-1:0]             col_s1;

	// running scores and best square
	logic [lfsq_pkg::SCORE_W-1:0] left_q;
	logic [lfsq_pkg::SCORE_W-1:0] diag_q;
	logic [lfsq_pkg::SCORE_W-1:0] best_size_q;
	logic [lfsq_pkg::ROW_W-1:0]   best_row_q;
	logic [COL_W-1:0]             best_col_q;

	// result register
	logic                         out_valid_q;
	logic [lfsq_pkg::SCORE_W-1:0] out_size_q;
	logic [lfsq_pkg::ROW_W-1:0]   out_row_q;
	logic [COL_W-1:0]             out_col_q;

	logic                         accept;
	logic                         s1_go;
	logic [lfsq_pkg::ROW_W-1:0]   rows_eff;
	logic [CMP_W-1:0]             cols_eff;
	logic [CMP_W-1:0]             col_nxt;
	logic [lfsq_pkg::ROW_W:0]     row_nxt;
	logic                         col_wrap;
	logic                         row_wrap;

	logic [lfsq_pkg::SCORE_W-1:0] up_raw;
	logic [lfsq_pkg::SCORE_W-1:0] up;
	logic [lfsq_pkg::SCORE_W-1:0] score;
	logic                         better;
	logic [lfsq_pkg::ROW_W-1:0]   best_row_new;
	logic [COL_W-1:0]             best_col_new;
	logic [lfsq_pkg::SCORE_W-1:0] fin_size;
	logic [lfsq_pkg::ROW_W-1:0]   fin_row;
	logic [COL_W-1:0]             fin_col;

	// ---------------------------------------------------------------
	// Configuration: always ready, unknown indexes are dropped
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q     <= lfsq_pkg::GRID_ROWS_RST;
			grid_columns_q  <= lfsq_pkg::GRID_COLUMNS_RST;
			obstacle_char_q <= lfsq_pkg::OBSTACLE_CHAR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				lfsq_pkg::CFG_GRID_ROWS: begin
					grid_rows_q <= cfg_data;
				end
				lfsq_pkg::CFG_GRID_COLUMNS: begin
					grid_columns_q <= cfg_data[lfsq_pkg::COLS_W-1:0];
				end
				lfsq_pkg::CFG_OBSTACLE_CHAR: begin
					obstacle_char_q <= cfg_data[lfsq_pkg::CHAR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Front end: raster counters advance as each item is accepted
	// ---------------------------------------------------------------
	// Stall the input register only when it holds a grid's last cell and the
	// previous result has not been taken yet.
	assign s1_go    = valid_s1 && !(ctx_s1.last_cell && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	always_comb begin
		// zero rows or columns act as one; columns beyond the line store clamp to it
		rows_eff = (grid_rows_q == '0) ? lfsq_pkg::ROW_W'(1) : grid_rows_q;
		if (grid_columns_q == '0) begin
			cols_eff = CMP_W'(1);
		end else if (CMP_W'(grid_columns_q) > CMP_W'(MAX_COLUMNS)) begin
			cols_eff = CMP_W'(MAX_COLUMNS);
		end else begin
			cols_eff = CMP_W'(grid_columns_q);
		end
		col_nxt  = CMP_W'(col_count_q) + 1'b1;
		row_nxt  = {1'b0, row_count_q} + 1'b1;
		col_wrap = col_nxt >= cols_eff;
		row_wrap = row_nxt >= {1'b0, rows_eff};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			col_count_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_count_q <= '0;
				row_count_q <= row_wrap ? '0 : row_nxt[lfsq_pkg::ROW_W-1:0];
			end else begin
				col_count_q <= col_nxt[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctx_s1.first_row <= row_count_q == '0;
			ctx_s1.first_col <= col_count_q == '0;
			ctx_s1.obstacle  <= cell_char == obstacle_char_q;
			ctx_s1.last_cell <= col_wrap && row_wrap;
			row_s1           <= row_count_q;
			col_s1           <= col_count_q;
		end
	end

	// ---------------------------------------------------------------
	// Line store: read the upper score as the item is accepted, write the
	// new score back as it leaves the input register
	// ---------------------------------------------------------------
	lfsq_line_store #(
		.DEPTH  (MAX_COLUMNS),
		.ADDR_W (COL_W)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_count_q),
		.rd_data (up_raw),
		.wr_en   (s1_go),
		.wr_addr (col_s1),
		.wr_data (score)
	);

	lfsq_score_calc #(
		.COL_W (COL_W)
	) u_score_calc (
		.ctx          (ctx_s1),
		.up_raw       (up_raw),
		.left_raw     (left_q),
		.diag_raw     (diag_q),
		.best_size    (best_size_q),
		.row          (row_s1),
		.col          (col_s1),
		.up           (up),
		.score        (score),
		.better       (better),
		.best_row_new (best_row_new),
		.best_col_new (best_col_new)
	);

	// best square including the cell now being scored
	always_comb begin
		fin_size = better ? score : best_size_q;
		fin_row  = better ? best_row_new : best_row_q;
		fin_col  = better ? best_col_new : best_col_q;
	end

	// ---------------------------------------------------------------
	// Running scores: advance per scored cell, restart best after a grid
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (s1_go) begin
			left_q <= score;
			diag_q <= up;
			if (ctx_s1.last_cell) begin
				best_size_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else begin
				best_size_q <= fin_size;
				best_row_q  <= fin_row;
				best_col_q  <= fin_col;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register: load on a grid's last cell, hold until taken
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && ctx_s1.last_cell) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && ctx_s1.last_cell) begin
			out_size_q <= fin_size;
			out_row_q  <= fin_row;
			out_col_q  <= fin_col;
		end
	end

	assign out_valid   = out_valid_q;
	assign square_size = out_size_q;
	assign top_row     = out_row_q;
	assign left_col    = lfsq_pkg::LCOL_W'(out_col_q);

endmodule

/* design/lfsq_line_store.sv */
// One-row score store: single write port, registered read with write-to-read bypass.
// Depends on lfsq_pkg for the score width and the default depth.
module lfsq_line_store #(
	parameter int DEPTH  = lfsq_pkg::DEFAULT_MAX_COLUMNS,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [lfsq_pkg::SCORE_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [lfsq_pkg::SCORE_W-1:0] wr_data
);

	logic [lfsq_pkg::SCORE_W-1:0] mem [DEPTH];
	logic [lfsq_pkg::SCORE_W-1:0] mem_rd_q;
	logic [lfsq_pkg::SCORE_W-1:0] byp_data_q;
	logic                         byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// a write landing on the address being read wins over the old contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : mem_rd_q;

endmodule

/* design/lfsq_score_calc.sv */
// Combinational scoring of one cell: min-plus-one of the neighbors and best-square check.
// Depends on lfsq_pkg for widths, the saturation value and the cell context type.
module lfsq_score_calc #(
	parameter int COL_W = 10
) (
	input  lfsq_pkg::cell_ctx_t           ctx,
	input  logic [lfsq_pkg::SCORE_W-1:0]  up_raw,
	input  logic [lfsq_pkg::SCORE_W-1:0]  left_raw,
	input  logic [lfsq_pkg::SCORE_W-1:0]  diag_raw,
	input  logic [lfsq_pkg::SCORE_W-1:0]  best_size,
	input  logic [lfsq_pkg::ROW_W-1:0]    row,
	input  logic [COL_W-1:0]              col,
	output logic [lfsq_pkg::SCORE_W-1:0]  up,
	output logic [lfsq_pkg::SCORE_W-1:0]  score,
	output logic                          better,
	output logic [lfsq_pkg::ROW_W-1:0]    best_row_new,
	output logic [COL_W-1:0]              best_col_new
);

	localparam int CC_W = (COL_W > lfsq_pkg::SCORE_W) ? COL_W : lfsq_pkg::SCORE_W;

	logic [lfsq_pkg::SCORE_W-1:0] left;
	logic [lfsq_pkg::SCORE_W-1:0] diag;
	logic [lfsq_pkg::SCORE_W-1:0] m_ul;
	logic [lfsq_pkg::SCORE_W-1:0] m_all;
	logic [lfsq_pkg::SCORE_W-1:0] span;
	logic [CC_W-1:0]              span_c;
	logic [CC_W-1:0]              col_c;
	logic [CC_W-1:0]              col_diff;

	always_comb begin
		// neighbors outside the grid count as zero
		up   = ctx.first_row ? '0 : up_raw;
		left = ctx.first_col ? '0 : left_raw;
		diag = (ctx.first_row || ctx.first_col) ? '0 : diag_raw;

		m_ul  = (left < up) ? left : up;
		m_all = (diag < m_ul) ? diag : m_ul;

		if (ctx.obstacle) begin
			score = '0;
		end else if (m_all == lfsq_pkg::SCORE_MAX) begin
			score = lfsq_pkg::SCORE_MAX;
		end else begin
			score = m_all + 1'b1;
		end

		better = score > best_size;
		span   = score - 1'b1;

		// back off to the top-left corner, clamped at zero
		if (lfsq_pkg::ROW_W'(span) > row) begin
			best_row_new = '0;
		end else begin
			best_row_new = row - lfsq_pkg::ROW_W'(span);
		end

		span_c   = CC_W'(span);
		col_c    = CC_W'(col);
		col_diff = col_c - span_c;
		best_col_new = (span_c > col_c) ? '0 : COL_W'(col_diff);
	end

endmodule
